@@ rtl/sirt_pkg.sv @@
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared constants, types and helpers for the signed integer to radix text
// converter: register indexes, symbol bank layout and unit status words.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int MAX_SYMBOLS   = 48;   // usable radix limit
  localparam int HELD_SYMBOLS  = 48;   // symbols held in the config bank
  localparam int SYM_WORDS     = HELD_SYMBOLS / 8;
  localparam int DIGIT_SLOTS   = 32;
  localparam int NUM_W         = 32;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int SLOT_IDX_W    = $clog2(DIGIT_SLOTS);
  localparam int COUNT_W       = $clog2(DIGIT_SLOTS + 1);

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS      = 4;
  localparam int DIV_STEPS     = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYM_FIRST   = 3'd1;

  typedef logic [SYM_WORDS-1:0][CFG_DATA_W-1:0] sym_bank_t;

  typedef struct packed {
    logic               done;
    logic               valid;
    logic [DIGIT_W-1:0] len;
  } chk_res_t;

  typedef struct packed {
    logic               done;
    logic [NUM_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

  // symbol byte at a table position; positions past the bank read as zero
  function automatic logic [CHAR_W-1:0] sym_at(input sym_bank_t bank,
                                               input logic [DIGIT_W-1:0] idx);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    if (idx < DIGIT_W'(HELD_SYMBOLS)) begin
      w = bank[idx[5:3]];
    end
    return w[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ rtl/sirt_table_check.sv @@
// ----------------------------------------------------------------------------
// sirt_table_check
// Finds the usable symbol count (length limit, first zero byte) by scanning
// one symbol a cycle, then checks for repeats one symbol a cycle against all
// later symbols in parallel.
// ----------------------------------------------------------------------------
module sirt_table_check
  import sirt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sym_bank_t          bank,
  input  logic [DIGIT_W-1:0] base_length,
  output chk_res_t           res
);

  typedef enum logic [2:0] {
    CK_IDLE = 3'b001,
    CK_LEN  = 3'b010,
    CK_DUP  = 3'b100
  } ck_state_t;

  ck_state_t          state_r, state_nxt;
  logic [DIGIT_W-1:0] idx_r, idx_nxt;
  logic [DIGIT_W-1:0] len_r, len_nxt;
  logic               done_r, done_nxt;
  logic               valid_r, valid_nxt;
  logic [DIGIT_W-1:0] lim;
  logic [CHAR_W-1:0]  cur_sym;
  logic               dup;

  assign lim = (base_length > DIGIT_W'(MAX_SYMBOLS)) ? DIGIT_W'(MAX_SYMBOLS) : base_length;
  assign cur_sym = sym_at(bank, idx_r);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < HELD_SYMBOLS; j++) begin
      if ((DIGIT_W'(j) > idx_r) && (DIGIT_W'(j) < len_r) &&
          (sym_at(bank, DIGIT_W'(j)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    done_nxt  = 1'b0;
    valid_nxt = valid_r;
    case (state_r)
      CK_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          state_nxt = CK_LEN;
        end
      end
      CK_LEN: begin
        if ((idx_r < lim) && (cur_sym != '0)) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          len_nxt   = idx_r;
          idx_nxt   = '0;
          state_nxt = CK_DUP;
        end
      end
      CK_DUP: begin
        if (len_r < DIGIT_W'(2)) begin
          done_nxt  = 1'b1;
          valid_nxt = 1'b0;
          state_nxt = CK_IDLE;
        end else if (({1'b0, idx_r} + 1'b1) >= {1'b0, len_r}) begin
          done_nxt  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = CK_IDLE;
        end else if (dup) begin
          done_nxt  = 1'b1;
          valid_nxt = 1'b0;
          state_nxt = CK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = CK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CK_IDLE;
      done_r  <= 1'b0;
      valid_r <= 1'b0;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.valid = valid_r;
  assign res.len   = len_r;

endmodule

@@ rtl/sirt_divider.sv @@
// ----------------------------------------------------------------------------
// sirt_divider
// Iterative restoring divider: 32-bit dividend by a 6-bit radix, four
// quotient bits per cycle. Done is registered along with the last step's result.
// ----------------------------------------------------------------------------
module sirt_divider
  import sirt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [DIGIT_W-1:0] divisor,
  output div_res_t           res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     q_r, q_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]     q_step;
  logic [DIGIT_W-1:0]   rem_step;
  logic [DIGIT_W:0]     trial;

  // shift in one dividend bit at a time, subtract when it fits
  always_comb begin
    q_step   = q_r;
    rem_step = rem_r;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial  = {rem_step, q_step[NUM_W-1]};
      q_step = {q_step[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        q_step[0] = 1'b1;
        rem_step  = DIGIT_W'(trial - {1'b0, divisor});
      end else begin
        rem_step  = DIGIT_W'(trial);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = q_r;
  assign res.remainder = rem_r;

endmodule

@@ rtl/signed_int_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Prints a signed 32-bit number as text in a radix set by a symbol table.
//
// Config: write base_length (index 0) and six 64-bit symbol words (index 1
// to 6, low byte first) through cfg_wr_en / cfg_index / cfg_wr_data while
// the block is idle. Any write marks the table for a fresh check.
// Input: in_number is taken when in_valid is high and in_stall is low; the
// block stalls its input from acceptance until the last character of that
// number has been loaded into the output register.
// Output: out_text_char / out_last_char, one character per word, minus sign
// first for negative numbers, then digits most significant first; held
// while out_stall is high. A bad table yields no words.
// Flow: the first number after a config change runs the table check over
// the usable symbols, which ends early when a repeat shows up. Each digit
// then comes from the shared divider (four quotient bits a cycle), and the
// characters go out back to back while the receiver keeps up.
// Reset: base_length and symbols clear to zero, the table is marked
// unchecked and the output is empty.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text
  import sirt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_W-1:0]       in_number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAR_W-1:0]      out_text_char,
  output logic                   out_last_char
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_SIGN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DIGIT_W-1:0]    base_len_r;
  sym_bank_t             sym_bank_r;
  logic                  dirty_r, dirty_nxt;
  logic                  tbl_ok_r, tbl_ok_nxt;
  logic [DIGIT_W-1:0]    len_r, len_nxt;
  logic                  neg_r, neg_nxt;
  logic [NUM_W-1:0]      mag_r, mag_nxt;
  logic                  kick_r, kick_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [SLOT_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [DIGIT_W-1:0]    digit_r [DIGIT_SLOTS];
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  chk_start;
  chk_res_t              chk;
  logic                  div_start;
  logic [NUM_W-1:0]      div_dividend;
  div_res_t              div;
  logic                  digit_we;
  logic                  slot_free;
  logic                  in_take;

  sirt_table_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (chk_start),
    .bank        (sym_bank_r),
    .base_length (base_len_r),
    .res         (chk)
  );

  sirt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len_r),
    .res      (div)
  );

  assign in_stall     = (state_r != ST_IDLE);
  assign in_take      = in_valid && !in_stall;
  assign slot_free    = !out_valid_r || !out_stall;
  assign div_dividend = kick_r ? mag_r : div.quotient;

  always_comb begin
    state_nxt     = state_r;
    dirty_nxt     = dirty_r;
    tbl_ok_nxt    = tbl_ok_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    kick_nxt      = 1'b0;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    chk_start     = 1'b0;
    div_start     = kick_r;
    digit_we      = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          neg_nxt = in_number[NUM_W-1];
          mag_nxt = in_number[NUM_W-1] ? (NUM_W'(0) - in_number) : in_number;
          if (dirty_r) begin
            chk_start = 1'b1;
            state_nxt = ST_CHECK;
          end else if (tbl_ok_r) begin
            kick_nxt  = 1'b1;
            count_nxt = '0;
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_CHECK: begin
        if (chk.done) begin
          dirty_nxt  = 1'b0;
          tbl_ok_nxt = chk.valid;
          len_nxt    = chk.len;
          if (chk.valid) begin
            kick_nxt  = 1'b1;
            count_nxt = '0;
            state_nxt = ST_DIVIDE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div.done) begin
          digit_we  = 1'b1;
          count_nxt = count_r + 1'b1;
          if ((div.quotient == '0) ||
              (count_r == COUNT_W'(DIGIT_SLOTS - 1))) begin
            ptr_nxt   = count_r[SLOT_IDX_W-1:0];
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_CHAR;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sym_at(sym_bank_r, digit_r[ptr_r]);
          out_last_nxt  = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // any table write forces a recheck
    if (cfg_wr_en) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dirty_r     <= 1'b1;
      tbl_ok_r    <= 1'b0;
      kick_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      base_len_r  <= '0;
      sym_bank_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      tbl_ok_r    <= tbl_ok_nxt;
      kick_r      <= kick_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == REG_BASE_LENGTH) begin
          base_len_r <= cfg_wr_data[DIGIT_W-1:0];
        end
        for (int m = 0; m < SYM_WORDS; m++) begin
          if (cfg_index == CFG_INDEX_W'(int'(REG_SYM_FIRST) + m)) begin
            sym_bank_r[m] <= cfg_wr_data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (digit_we) begin
      digit_r[count_r[SLOT_IDX_W-1:0]] <= div.remainder;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule
